[hdl/cssw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cssw_pkg
// widths and defaults shared by the coverage cell span sweep modules
// ----------------------------------------------------------------------------
package cssw_pkg;

  // coordinate and length fields
  localparam int COORD_BITS = 16;
  localparam int LEN_BITS   = 16;

  // cell payload widths
  localparam int CELL_COVER_BITS = 16;
  localparam int AREA_BITS       = 25;

  // running cover accumulator width, wraps on overflow
  localparam int COVER_BITS = 24;

  // alpha output width
  localparam int ALPHA_BITS = 8;

  // default subpixel resolution
  localparam int SUBPIXEL_SHIFT_DEF = 8;

  // apb port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

endpackage : cssw_pkg
`default_nettype wire

[hdl/cssw_cov.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cssw_cov
// coverage to alpha: floor-shifted signed area, abs, even-odd fold, saturate
// ----------------------------------------------------------------------------
module cssw_cov #(
  parameter int SUBPIXEL_SHIFT = cssw_pkg::SUBPIXEL_SHIFT_DEF
) (
  input  wire logic signed [cssw_pkg::COVER_BITS-1:0] cover_sum,
  input  wire logic signed [cssw_pkg::AREA_BITS-1:0]  area,
  input  wire logic                                   even_odd,
  output logic             [cssw_pkg::ALPHA_BITS-1:0] alpha
);
  import cssw_pkg::*;

  localparam int SH1   = SUBPIXEL_SHIFT + 1;
  localparam int DW    = COVER_BITS + SH1 + 1;
  localparam int QW    = COVER_BITS + 1;
  localparam int FW    = SUBPIXEL_SHIFT + 2;
  localparam int SCALE = 1 << SUBPIXEL_SHIFT;
  localparam int LSH   = (SUBPIXEL_SHIFT < ALPHA_BITS) ? ALPHA_BITS - SUBPIXEL_SHIFT : 0;
  localparam int RSH   = (SUBPIXEL_SHIFT > ALPHA_BITS) ? SUBPIXEL_SHIFT - ALPHA_BITS : 0;

  logic signed [DW-1:0] cov_sh;
  logic signed [DW-1:0] area_ext;
  logic signed [DW-1:0] diff;
  logic signed [QW-1:0] q;
  logic        [QW-1:0] mag;
  logic        [FW-1:0] fold;
  logic        [FW-1:0] folded;
  logic        [QW-1:0] sel;
  logic [SUBPIXEL_SHIFT-1:0] frac;

  always_comb begin
    cov_sh   = DW'(cover_sum) <<< SH1;
    area_ext = DW'(area);
    diff     = cov_sh - area_ext;
    // arithmetic drop of the low bits is a floor shift
    q        = diff[DW-1:SH1];
    mag      = q[QW-1] ? QW'(-q) : QW'(q);
    // modulo 2*scale, mirrored about scale
    fold     = FW'(mag[SUBPIXEL_SHIFT:0]);
    folded   = (fold > FW'(SCALE)) ? FW'(2 * SCALE) - fold : fold;
    sel      = even_odd ? QW'(folded) : mag;
    frac     = sel[SUBPIXEL_SHIFT-1:0];
    if (sel >= QW'(SCALE - 1)) begin
      alpha = '1;
    end else begin
      alpha = ALPHA_BITS'((32'(frac) << LSH) >> RSH);
    end
  end

endmodule : cssw_cov
`default_nettype wire

[hdl/coverage_cell_span_sweep.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// coverage_cell_span_sweep
// turns sorted, merged scanline cells into anti-aliased spans
// ----------------------------------------------------------------------------
// usage
//   input channel (in_*): one cell per item, x strictly rising within a line,
//   in_first_in_line set on the first cell of every scanline
//   result channel (out_*): per cell an optional gap span (out_last = 0)
//   followed by the one-pixel span of the cell itself (out_last = 1)
//   apb port: register 0 at address 0 selects even-odd (1) or nonzero (0)
//   fill; write it only while no cell is in flight
// path: a taken cell moves from the input register into the result pair
// throughput: one cell per cycle when no gap span is given and out_stall is low;
//   a cell with a gap span keeps the result pair busy for both its spans, as
//   the single result channel carries up to two spans per cell
// reset: running cover, previous x and even_odd clear, both stages empty
// stall: a stalled span holds; the input register and the result pair
//   keep filling, then in_stall rises until the result pair drains
// ----------------------------------------------------------------------------
module coverage_cell_span_sweep #(
  parameter int SUBPIXEL_SHIFT = cssw_pkg::SUBPIXEL_SHIFT_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  // cell input
  input  wire logic                                          in_valid,
  output logic                                               in_stall,
  input  wire logic signed [cssw_pkg::COORD_BITS-1:0]        in_cell_x,
  input  wire logic signed [cssw_pkg::CELL_COVER_BITS-1:0]   in_cell_cover,
  input  wire logic signed [cssw_pkg::AREA_BITS-1:0]         in_cell_area,
  input  wire logic                                          in_first_in_line,
  // span output
  output logic                                               out_valid,
  input  wire logic                                          out_stall,
  output logic signed [cssw_pkg::COORD_BITS-1:0]             out_span_x,
  output logic        [cssw_pkg::LEN_BITS-1:0]               out_span_length,
  output logic        [cssw_pkg::ALPHA_BITS-1:0]             out_coverage,
  output logic                                               out_last,
  // configuration
  input  wire logic                                          psel,
  input  wire logic                                          penable,
  input  wire logic                                          pwrite,
  input  wire logic        [cssw_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  wire logic        [cssw_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic             [cssw_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                               pready
);
  import cssw_pkg::*;

  // register index sits in the word address bit
  localparam logic REG_EVEN_ODD = 1'b0;

  localparam int XE = COORD_BITS + 1;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic even_odd_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_EVEN_ODD) begin
      prdata[0] = even_odd_r;
    end
  end

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  logic a_valid_r;       // input register holds a cell
  logic b_gap_v_r;       // result pair: gap span pending
  logic b_cell_v_r;      // result pair: cell span pending
  logic b_free;
  logic a_move;
  logic in_take;

  // result pair frees once nothing is left but a cell span being taken now
  assign b_free   = !b_gap_v_r && (!b_cell_v_r || !out_stall);
  assign a_move   = a_valid_r && b_free;
  assign in_stall = a_valid_r && !b_free;
  assign in_take  = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // line state, updated as each cell is taken
  // ---------------------------------------------------------------------------
  logic signed [COVER_BITS-1:0] rc_r, rc_nxt;
  logic signed [COORD_BITS-1:0] prev_x_r;
  logic signed [XE-1:0]         x_ext;
  logic signed [XE-1:0]         px1;
  logic signed [XE-1:0]         gap_len_w;
  logic                         gap_w;

  always_comb begin
    x_ext     = XE'(in_cell_x);
    px1       = XE'(prev_x_r) + XE'(1);
    gap_len_w = x_ext - px1;
    // gap only between non-adjacent cells and under nonzero winding so far
    gap_w     = !in_first_in_line && (x_ext > px1) && (rc_r != '0);
    if (in_first_in_line) begin
      rc_nxt = COVER_BITS'(in_cell_cover);
    end else begin
      rc_nxt = rc_r + COVER_BITS'(in_cell_cover);
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic                         a_gap_r;
  logic signed [COORD_BITS-1:0] a_gap_x_r;
  logic        [LEN_BITS-1:0]   a_gap_len_r;
  logic signed [COVER_BITS-1:0] a_old_rc_r;
  logic signed [COORD_BITS-1:0] a_x_r;
  logic signed [COVER_BITS-1:0] a_new_rc_r;
  logic signed [AREA_BITS-1:0]  a_area_r;

  // ---------------------------------------------------------------------------
  // coverage of both spans
  // ---------------------------------------------------------------------------
  logic [ALPHA_BITS-1:0] gap_alpha;
  logic [ALPHA_BITS-1:0] cell_alpha;

  cssw_cov #(
    .SUBPIXEL_SHIFT (SUBPIXEL_SHIFT)
  ) u_gap_cov (
    .cover_sum (a_old_rc_r),
    .area      ('0),
    .even_odd  (even_odd_r),
    .alpha     (gap_alpha)
  );

  cssw_cov #(
    .SUBPIXEL_SHIFT (SUBPIXEL_SHIFT)
  ) u_cell_cov (
    .cover_sum (a_new_rc_r),
    .area      (a_area_r),
    .even_odd  (even_odd_r),
    .alpha     (cell_alpha)
  );

  // ---------------------------------------------------------------------------
  // result pair
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] b_gap_x_r;
  logic        [LEN_BITS-1:0]   b_gap_len_r;
  logic        [ALPHA_BITS-1:0] b_gap_cov_r;
  logic signed [COORD_BITS-1:0] b_cell_x_r;
  logic        [ALPHA_BITS-1:0] b_cell_cov_r;
  logic                         b_gap_v_nxt;
  logic                         b_cell_v_nxt;
  logic                         a_valid_nxt;

  always_comb begin
    b_gap_v_nxt  = b_gap_v_r;
    b_cell_v_nxt = b_cell_v_r;
    priority if (a_move) begin
      b_gap_v_nxt  = a_gap_r;
      b_cell_v_nxt = 1'b1;
    end else if (out_valid && !out_stall) begin
      // gap span leaves first, the cell span after it
      if (b_gap_v_r) begin
        b_gap_v_nxt = 1'b0;
      end else begin
        b_cell_v_nxt = 1'b0;
      end
    end else begin
      // nothing moves, the pair holds
      b_gap_v_nxt  = b_gap_v_r;
      b_cell_v_nxt = b_cell_v_r;
    end
    a_valid_nxt = in_take || (a_valid_r && !a_move);
  end

  // control and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      even_odd_r <= 1'b0;
      a_valid_r  <= 1'b0;
      b_gap_v_r  <= 1'b0;
      b_cell_v_r <= 1'b0;
      rc_r       <= '0;
      prev_x_r   <= '0;
    end else begin
      if (cfg_wr && paddr[2] == REG_EVEN_ODD) begin
        even_odd_r <= pwdata[0];
      end
      a_valid_r  <= a_valid_nxt;
      b_gap_v_r  <= b_gap_v_nxt;
      b_cell_v_r <= b_cell_v_nxt;
      if (in_take) begin
        rc_r     <= rc_nxt;
        prev_x_r <= in_cell_x;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_gap_r     <= gap_w;
      a_gap_x_r   <= COORD_BITS'(px1);
      a_gap_len_r <= LEN_BITS'(gap_len_w);
      a_old_rc_r  <= rc_r;
      a_x_r       <= in_cell_x;
      a_new_rc_r  <= rc_nxt;
      a_area_r    <= in_cell_area;
    end
    if (a_move) begin
      b_gap_x_r    <= a_gap_x_r;
      b_gap_len_r  <= a_gap_len_r;
      b_gap_cov_r  <= gap_alpha;
      b_cell_x_r   <= a_x_r;
      b_cell_cov_r <= cell_alpha;
    end
  end

  // ---------------------------------------------------------------------------
  // output select
  // ---------------------------------------------------------------------------
  assign out_valid       = b_gap_v_r || b_cell_v_r;
  assign out_last        = !b_gap_v_r;
  assign out_span_x      = b_gap_v_r ? b_gap_x_r : b_cell_x_r;
  assign out_span_length = b_gap_v_r ? b_gap_len_r : LEN_BITS'(1);
  assign out_coverage    = b_gap_v_r ? b_gap_cov_r : b_cell_cov_r;

endmodule : coverage_cell_span_sweep
`default_nettype wire

[hdl/cssw_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cssw_checker
// port-level checks on the span sweep, bound to the top level
// ----------------------------------------------------------------------------
module cssw_checker (
  input wire logic                                          clk,
  input wire logic                                          rst_n,
  input wire logic                                          out_valid,
  input wire logic                                          out_stall,
  input wire logic signed [cssw_pkg::COORD_BITS-1:0]        out_span_x,
  input wire logic        [cssw_pkg::LEN_BITS-1:0]          out_span_length,
  input wire logic        [cssw_pkg::ALPHA_BITS-1:0]        out_coverage,
  input wire logic                                          out_last
);
  import cssw_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("span valid right after reset");

  // a stalled span holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_span_x)
      && $stable(out_span_length) && $stable(out_coverage) && $stable(out_last))
    else $error("stalled span changed");

  // a gap span is always followed at once by its cell span
  a_gap_then_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && !out_stall |=> out_valid && out_last)
    else $error("gap span not followed by cell span");

  // cell spans are one pixel, gap spans never empty
  a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last ? (out_span_length == LEN_BITS'(1))
                            : (out_span_length != '0)))
    else $error("bad span length");

endmodule : cssw_checker

bind coverage_cell_span_sweep cssw_checker u_cssw_checker (.*);
`default_nettype wire

[verif/tb_coverage_cell_span_sweep.sv]
// ----------------------------------------------------------------------------
// tb_coverage_cell_span_sweep
// self-checking bench for the scanline coverage cell span sweep
// ----------------------------------------------------------------------------
// cells go in through the valid/stall input channel, spans come back through
// the valid/stall result channel. a small scoreboard class predicts every span
// from its own copy of the running cover, previous x and fill rule, and checks
// the spans in order. stimulus is a short directed part, then random scanlines
// under three idling patterns, with a long receiver hold-off, a full drain
// mid-phase and a running cover wrap line
// ----------------------------------------------------------------------------
module tb_coverage_cell_span_sweep;
  import cssw_pkg::*;

  // register addresses on the apb port
  localparam logic [APB_ADDR_BITS-1:0] ADDR_EVEN_ODD = 3'd0;

  // fill rule encodings of the even_odd register
  localparam logic [APB_DATA_BITS-1:0] FILL_NONZERO  = 32'd0;
  localparam logic [APB_DATA_BITS-1:0] FILL_EVEN_ODD = 32'd1;

  // bench limits
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_TICKS = 6;

  // one span as seen on the result channel
  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic        [LEN_BITS-1:0]   len;
    logic        [ALPHA_BITS-1:0] alpha;
    logic                         last;
  } span_t;

  // --------------------------------------------------------------------------
  // span scoreboard: predicts spans per accepted cell, checks them in order
  // --------------------------------------------------------------------------
  class span_scoreboard;
    localparam int SUB = SUBPIXEL_SHIFT_DEF;

    logic signed [COVER_BITS-1:0] run_cover;
    logic signed [COORD_BITS-1:0] prev_x;
    bit                           even_odd;
    span_t                        pending_spans[$];
    int                           errors;

    function new();
      run_cover = '0;
      prev_x    = '0;
      even_odd  = 1'b0;
      errors    = 0;
    endfunction

    // alpha from cover and area, floor shift, abs, optional even-odd fold
    function logic [ALPHA_BITS-1:0] alpha_of(longint cvr, longint area);
      longint c;
      longint q;
      longint scale;
      scale = longint'(1) << SUB;
      c = (cvr << (SUB + 1)) - area;
      q = c >>> (SUB + 1);
      if (q < 0) q = -q;
      if (even_odd) begin
        q = q & (2 * scale - 1);
        if (q > scale) q = 2 * scale - q;
      end
      if (q >= scale - 1) return '1;
      if (SUB < 8) q = q << (8 - SUB);
      else if (SUB > 8) q = q >> (SUB - 8);
      return q[ALPHA_BITS-1:0];
    endfunction

    // an accepted cell: optional gap span, then the one-pixel span
    function void note_cell(logic signed [COORD_BITS-1:0] x,
                            logic signed [CELL_COVER_BITS-1:0] cvr,
                            logic signed [AREA_BITS-1:0] area, logic first);
      longint px;
      longint xl;
      span_t  s;
      xl = longint'(x);
      if (first) begin
        run_cover = COVER_BITS'(longint'(cvr));
      end else begin
        px = longint'(prev_x);
        // gap only for non-adjacent cells under a nonzero running cover
        if (xl > px + 1 && run_cover != 0) begin
          s.x     = COORD_BITS'(px + 1);
          s.len   = LEN_BITS'(xl - px - 1);
          s.alpha = alpha_of(longint'(run_cover), 0);
          s.last  = 1'b0;
          pending_spans.push_back(s);
        end
        // running cover wraps at its width
        run_cover = COVER_BITS'(longint'(run_cover) + longint'(cvr));
      end
      s.x     = x;
      s.len   = LEN_BITS'(1);
      s.alpha = alpha_of(longint'(run_cover), longint'(area));
      s.last  = 1'b1;
      pending_spans.push_back(s);
      prev_x = x;
    endfunction

    function void check_span(logic signed [COORD_BITS-1:0] x, logic [LEN_BITS-1:0] len,
                             logic [ALPHA_BITS-1:0] alpha, logic last);
      span_t e;
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected span x %0d len %0d alpha %0d last %0b",
                 $time, x, len, alpha, last);
        errors++;
        return;
      end
      e = pending_spans.pop_front();
      if (x !== e.x) begin
        $display("%0t: span_x expected %0d got %0d", $time, e.x, x);
        errors++;
      end
      if (len !== e.len) begin
        $display("%0t: span_length expected %0d got %0d", $time, e.len, len);
        errors++;
      end
      if (alpha !== e.alpha) begin
        $display("%0t: coverage expected %0d got %0d", $time, e.alpha, alpha);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %0b got %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic signed [COORD_BITS-1:0]       in_cell_x = '0;
  logic signed [CELL_COVER_BITS-1:0]  in_cell_cover = '0;
  logic signed [AREA_BITS-1:0]        in_cell_area = '0;
  logic                               in_first_in_line = 1'b0;

  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [COORD_BITS-1:0]       out_span_x;
  logic        [LEN_BITS-1:0]         out_span_length;
  logic        [ALPHA_BITS-1:0]       out_coverage;
  logic                               out_last;

  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic        [APB_ADDR_BITS-1:0]    paddr = '0;
  logic        [APB_DATA_BITS-1:0]    pwdata = '0;
  logic        [APB_DATA_BITS-1:0]    prdata;
  logic                               pready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  coverage_cell_span_sweep dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cell_x        (in_cell_x),
    .in_cell_cover    (in_cell_cover),
    .in_cell_area     (in_cell_area),
    .in_first_in_line (in_first_in_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_span_x       (out_span_x),
    .out_span_length  (out_span_length),
    .out_coverage     (out_coverage),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  span_scoreboard sb;

  // idling percentages of each side, set per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // hold-off requests: bumped by the stimulus, served by the receiver
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // phase bookkeeping for the random scanlines
  int phase_items = 0;
  int phase_sent = 0;

  int cycle_count = 0;

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d spans outstanding", $time, sb.pending_spans.size());
      $display("tb_coverage_cell_span_sweep failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall, plus long hold-offs counted here
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_span(out_span_x, out_span_length, out_coverage, out_last);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // offer one cell, optionally after an idle gap, hold it until accepted
  task automatic send_cell(input logic signed [COORD_BITS-1:0] x,
                           input logic signed [CELL_COVER_BITS-1:0] cvr,
                           input logic signed [AREA_BITS-1:0] area, input logic first);
    int gap;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_cell_x        = x;
    in_cell_cover    = cvr;
    in_cell_area     = area;
    in_first_in_line = first;
    do @(posedge clk); while (in_stall);
    sb.note_cell(x, cvr, area, first);
  endtask

  // stop offering and wait until every predicted span has come back
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_spans.size() != 0) @(posedge clk);
    // then let the pipe settle so that any stray span still shows
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, done when pready is seen
  task automatic cfg_write(input logic [APB_ADDR_BITS-1:0] addr,
                           input logic [APB_DATA_BITS-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_EVEN_ODD) sb.even_odd = data[0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // random field values
  // --------------------------------------------------------------------------

  // cover: mostly near one pixel, sometimes full range or an extreme
  function automatic logic signed [CELL_COVER_BITS-1:0] pick_cover();
    logic signed [CELL_COVER_BITS-1:0] v;
    case ($urandom_range(9))
      0:       v = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1, 2:    v = CELL_COVER_BITS'($urandom);
      default: v = CELL_COVER_BITS'(int'($urandom_range(0, 1200)) - 600);
    endcase
    return v;
  endfunction

  // area: mostly a fraction of cover * 512 so alpha lands mid-range
  function automatic logic signed [AREA_BITS-1:0] pick_area(
      logic signed [CELL_COVER_BITS-1:0] cvr);
    logic signed [AREA_BITS-1:0] v;
    case ($urandom_range(7))
      0:       v = $urandom_range(1) ? 25'sh0ffffff : 25'sh1000000;
      1, 2:    v = AREA_BITS'($urandom);
      default: v = AREA_BITS'(longint'(cvr) * int'($urandom_range(0, 512))
                              + int'($urandom_range(0, 1023)) - 512);
    endcase
    return v;
  endfunction

  // one random cell of the current phase, with the mid-phase pressure events
  task automatic phase_cell(input logic signed [COORD_BITS-1:0] x, input logic first);
    logic signed [CELL_COVER_BITS-1:0] cv;
    cv = pick_cover();
    send_cell(x, cv, pick_area(cv), first);
    phase_sent++;
    // sender pauses until the block has given everything back
    if (phase_sent == phase_items / 3) wait_drain();
    // receiver holds off while the sender keeps pushing
    if (phase_sent == phase_items / 2) hold_req++;
  endtask

  // random scanlines: sorted x with mixed steps, a little unordered noise
  task automatic run_lines(input int n_items);
    int x;
    int line_len;
    int step;
    int r;
    int k;
    phase_items = n_items;
    phase_sent  = 0;
    while (phase_sent < n_items) begin
      x        = int'($urandom_range(0, 65535)) - 32768;
      line_len = $urandom_range(1, 14);
      phase_cell(COORD_BITS'(x), 1'b1);
      for (k = 1; k < line_len && phase_sent < n_items; k++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          // broken order: any x, may sit at or behind the previous cell
          x = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          if (r < 55) step = 1;
          else if (r < 92) step = $urandom_range(2, 24);
          else step = $urandom_range(25, 4000);
          if (x + step > 32767) break;
          x += step;
        end
        phase_cell(COORD_BITS'(x), 1'b0);
      end
    end
  endtask

  // one long line of large positive covers, so the running cover wraps
  task automatic run_wrap_line(input int n_cells);
    int x;
    int k;
    logic signed [CELL_COVER_BITS-1:0] cv;
    x = -32768;
    send_cell(COORD_BITS'(x), 16'sh7fff, '0, 1'b1);
    for (k = 1; k < n_cells; k++) begin
      x += $urandom_range(1, 2);
      cv = CELL_COVER_BITS'(32767 - int'($urandom_range(0, 300)));
      send_cell(COORD_BITS'(x), cv, pick_area(cv), 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed, nonzero winding ----
    cfg_write(ADDR_EVEN_ODD, FILL_NONZERO);
    // first item after reset without a line start, running cover still zero
    send_cell(16'sd100, 16'sd10, 25'sd0, 1'b0);
    // line start at the lowest x with the largest cover
    send_cell(16'sh8000, 16'sh7fff, 25'sd0, 1'b1);
    // widest gap: lowest to highest x, smallest cover and area
    send_cell(16'sh7fff, 16'sh8000, 25'sh1000000, 1'b0);
    // new line, zero cover, largest area
    send_cell(16'sd0, 16'sd0, 25'sh0ffffff, 1'b1);
    // gap suppressed because the running cover is zero
    send_cell(16'sd5, 16'sd100, 25'sd0, 1'b0);
    // adjacent cell, half covered
    send_cell(16'sd6, 16'sd0, 25'sd25600, 1'b0);
    // area of one with no cover: floor shift rounds toward minus infinity
    send_cell(16'sd7, 16'sd0, 25'sd1, 1'b0);
    // same x again: no gap, still accumulated
    send_cell(16'sd7, -16'sd50, 25'sd0, 1'b0);
    // x behind the previous cell
    send_cell(16'sd3, 16'sd20, -25'sd4000, 1'b0);
    // real gap under a nonzero cover, negative area
    send_cell(16'sd20, 16'sd0, -25'sd1, 1'b0);
    // negative running cover gives the same alpha by absolute value
    send_cell(16'sd25, -16'sd400, 25'sd0, 1'b0);
    wait_drain();

    // ---- directed, even-odd ----
    cfg_write(ADDR_EVEN_ODD, FILL_EVEN_ODD);
    // cover above one pixel folds back
    send_cell(16'sd10, 16'sd384, 25'sd0, 1'b1);
    // gap at 384, then two pixels of cover fold to zero
    send_cell(16'sd12, 16'sd128, 25'sd0, 1'b0);
    // three pixels land exactly on the fold point
    send_cell(16'sd13, 16'sd256, 25'sd0, 1'b0);
    // big negative cover with the smallest area
    send_cell(16'sd14, -16'sd2000, 25'sh1000000, 1'b0);
    // gap with a negative cover folded
    send_cell(16'sd40, 16'sd0, 25'sd200, 1'b0);
    // extremes in even-odd mode
    send_cell(16'sh7fff, 16'sh7fff, 25'sh0ffffff, 1'b0);
    send_cell(16'sh8000, 16'sh8000, 25'sh1000000, 1'b1);
    wait_drain();

    // ---- random, sender idles a little, receiver a lot ----
    cfg_write(ADDR_EVEN_ODD, FILL_NONZERO);
    send_idle_pct = 22;
    recv_idle_pct = 77;
    run_lines(560);
    wait_drain();

    // ---- random, sender idles a lot, receiver a little ----
    cfg_write(ADDR_EVEN_ODD, FILL_EVEN_ODD);
    send_idle_pct = 77;
    recv_idle_pct = 22;
    run_lines(560);
    wait_drain();

    // ---- random, no idling, running cover wrap ----
    cfg_write(ADDR_EVEN_ODD, FILL_NONZERO);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_lines(480);
    run_wrap_line(300);
    wait_drain();

    // ---- verdict ----
    if (sb.pending_spans.size() != 0)
      $display("%0t: %0d expected spans never came", $time, sb.pending_spans.size());
    if (sb.errors == 0 && sb.pending_spans.size() == 0) begin
      $display("tb_coverage_cell_span_sweep passed");
    end else begin
      $display("tb_coverage_cell_span_sweep failed");
    end
    $finish;
  end

endmodule
